[src/pfde_pkg.sv]
// Shared constants for the page framebuffer draw engine: command codes,
// field widths and the default store geometry. No dependencies.
`timescale 1ns / 1ps

package pfde_pkg;

   // command codes
   localparam logic [1:0] ACT_PIXEL = 2'd0;
   localparam logic [1:0] ACT_RECT  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // field widths
   localparam int ACTION_W = 2;
   localparam int POS_X_W  = 7;
   localparam int POS_Y_W  = 6;
   localparam int RECT_W_W = 8;
   localparam int RECT_H_W = 7;
   localparam int RPAGE_W  = 3;
   localparam int RCOL_W   = 7;
   localparam int BYTE_W   = 8;

   localparam int PIX_PER_BYTE = 8;

   // working widths: column sums reach 381, row sums reach 189
   localparam int COL_CALC_W = 9;
   localparam int ROW_CALC_W = 8;

   localparam int PAGES_DEFAULT   = 8;
   localparam int COLUMNS_DEFAULT = 128;

endpackage

[src/page_framebuffer_draw_engine.sv]
// Page framebuffer draw engine: one block RAM of PAGES*COLUMNS bytes, read-modify-write walker.
// Throughput: one command at a time; the walker does one page byte per cycle through the RAM.
// Reset: synchronous; a clearing pass over all PAGES*COLUMNS bytes zeroes the store, req_stall high.
// A finished result waits in the response register while the next command is taken.
`timescale 1ns / 1ps

module page_framebuffer_draw_engine #(
   parameter int PAGES   = pfde_pkg::PAGES_DEFAULT,
   parameter int COLUMNS = pfde_pkg::COLUMNS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pfde_pkg::ACTION_W-1:0]    req_action,
   input  logic [pfde_pkg::POS_X_W-1:0]     req_pos_x,
   input  logic [pfde_pkg::POS_Y_W-1:0]     req_pos_y,
   input  logic [pfde_pkg::RECT_W_W-1:0]    req_rect_width,
   input  logic [pfde_pkg::RECT_H_W-1:0]    req_rect_height,
   input  logic                             req_ink,
   input  logic                             req_solid,
   input  logic [pfde_pkg::RPAGE_W-1:0]     req_read_page,
   input  logic [pfde_pkg::RCOL_W-1:0]      req_read_column,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pfde_pkg::BYTE_W-1:0]      rsp_page_byte
);

   import pfde_pkg::*;

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROWS  = PAGES * PIX_PER_BYTE;
   localparam int PGW   = ROW_CALC_W - $clog2(PIX_PER_BYTE);

   // controller states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;  // zeroing sweep, one byte per cycle
   localparam logic [2:0] ST_SETUP = 3'd2;  // clip the rectangle
   localparam logic [2:0] ST_WALK  = 3'd3;  // issue reads, write back in the next cycle
   localparam logic [2:0] ST_DRAIN = 3'd4;  // last write-back
   localparam logic [2:0] ST_RADDR = 3'd5;
   localparam logic [2:0] ST_RDATA = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;  // hand result to response register

   logic [2:0]             st_ff, st_in;

   // command held for the duration of the transfer's work
   logic [POS_X_W-1:0]     cmd_x_ff, cmd_x_in;
   logic [POS_Y_W-1:0]     cmd_y_ff, cmd_y_in;
   logic [RECT_W_W-1:0]    cmd_w_ff, cmd_w_in;
   logic [RECT_H_W-1:0]    cmd_h_ff, cmd_h_in;
   logic                   cmd_ink_ff, cmd_ink_in;
   logic                   cmd_solid_ff, cmd_solid_in;
   logic [RPAGE_W-1:0]     cmd_rpage_ff, cmd_rpage_in;
   logic [RCOL_W-1:0]      cmd_rcol_ff, cmd_rcol_in;

   // clipped rectangle bounds
   logic [COL_CALC_W-1:0]  xlast_ff, xlast_in;   // unclipped right edge
   logic [COL_CALC_W-1:0]  xend_ff, xend_in;     // clipped right edge
   logic [ROW_CALC_W-1:0]  y1raw_ff, y1raw_in;   // unclipped bottom edge
   logic [ROW_CALC_W-1:0]  y1c_ff, y1c_in;       // clipped bottom edge

   // walker position
   logic [PGW-1:0]         pg_ff, pg_in;
   logic [COL_CALC_W-1:0]  col_ff, col_in;

   // clearing sweep
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   clr_rsp_ff, clr_rsp_in;   // sweep came from a command

   // write-back stage
   logic                   wr_pend_ff, wr_pend_in;
   logic [AW-1:0]          wr_addr_ff, wr_addr_in;
   logic [BYTE_W-1:0]      wr_mask_ff, wr_mask_in;

   logic [BYTE_W-1:0]      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;

   // frame store
   logic [BYTE_W-1:0]      mem [DEPTH];
   logic [BYTE_W-1:0]      rd_data_ff;
   logic [AW-1:0]          mem_raddr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [BYTE_W-1:0]      mem_wdata;

   logic                   req_take;
   logic                   rsp_free;
   logic [AW-1:0]          walk_addr;
   logic [AW-1:0]          read_addr;
   logic [BYTE_W-1:0]      walk_mask;
   logic                   walk_side;
   logic [ROW_CALC_W-1:0]  row_y0;
   logic [ROW_CALC_W-1:0]  row_b;
   logic [COL_CALC_W-1:0]  col_x0;
   logic                   rect_empty;
   logic                   read_in_range;

   assign req_stall = (st_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_page_byte = rsp_byte_ff;

   assign row_y0 = ROW_CALC_W'(cmd_y_ff);
   assign col_x0 = COL_CALC_W'(cmd_x_ff);

   assign rect_empty = (cmd_w_ff == '0) || (cmd_h_ff == '0) ||
                       (col_x0 >= COL_CALC_W'(COLUMNS)) || (row_y0 >= ROW_CALC_W'(ROWS));

   assign walk_addr = AW'(AW'(pg_ff) * AW'(COLUMNS) + AW'(col_ff));
   assign read_addr = AW'(AW'(cmd_rpage_ff) * AW'(COLUMNS) + AW'(cmd_rcol_ff));

   assign read_in_range = (5'(cmd_rpage_ff) < 5'(PAGES)) &&
                          (COL_CALC_W'(cmd_rcol_ff) < COL_CALC_W'(COLUMNS));

   // Pixels of the current page byte that the rectangle touches. Left and right
   // columns (and solid fills) take the whole clipped row span; inner columns
   // of an outline only take the top and bottom rows.
   assign walk_side = cmd_solid_ff || (col_ff == col_x0) || (col_ff == xlast_ff);

   always_comb begin
      row_b = '0;
      for (int b = 0; b < PIX_PER_BYTE; b++) begin
         row_b        = {pg_ff, 3'(b)};
         walk_mask[b] = (row_b >= row_y0) && (row_b <= y1c_ff) &&
                        (walk_side || (row_b == row_y0) || (row_b == y1raw_ff));
      end
   end

   // memory port selection
   assign mem_raddr = (st_ff == ST_RADDR) ? read_addr : walk_addr;
   assign mem_we    = (st_ff == ST_CLEAR) || wr_pend_ff;
   assign mem_waddr = (st_ff == ST_CLEAR) ? clr_addr_ff : wr_addr_ff;
   assign mem_wdata = (st_ff == ST_CLEAR) ? '0 :
                      cmd_ink_ff ? (rd_data_ff | wr_mask_ff) : (rd_data_ff & ~wr_mask_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // next-state and datapath
   always_comb begin
      st_in         = st_ff;
      cmd_x_in      = cmd_x_ff;
      cmd_y_in      = cmd_y_ff;
      cmd_w_in      = cmd_w_ff;
      cmd_h_in      = cmd_h_ff;
      cmd_ink_in    = cmd_ink_ff;
      cmd_solid_in  = cmd_solid_ff;
      cmd_rpage_in  = cmd_rpage_ff;
      cmd_rcol_in   = cmd_rcol_ff;
      xlast_in      = xlast_ff;
      xend_in       = xend_ff;
      y1raw_in      = y1raw_ff;
      y1c_in        = y1c_ff;
      pg_in         = pg_ff;
      col_in        = col_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = walk_addr;
      wr_mask_in    = walk_mask;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_x_in      = req_pos_x;
               cmd_y_in      = req_pos_y;
               cmd_w_in      = req_rect_width;
               cmd_h_in      = req_rect_height;
               cmd_ink_in    = req_ink;
               cmd_solid_in  = req_solid;
               cmd_rpage_in  = req_read_page;
               cmd_rcol_in   = req_read_column;
               res_in        = '0;
               unique case (req_action)
                  ACT_PIXEL: begin
                     // a pixel is a solid 1x1 rectangle
                     cmd_w_in     = RECT_W_W'(1);
                     cmd_h_in     = RECT_H_W'(1);
                     cmd_solid_in = 1'b1;
                     st_in        = ST_SETUP;
                  end
                  ACT_RECT: begin
                     st_in = ST_SETUP;
                  end
                  ACT_CLEAR: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     st_in       = ST_CLEAR;
                  end
                  ACT_READ: begin
                     st_in = ST_RADDR;
                  end
                  default: begin
                     st_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_addr_in = AW'(clr_addr_ff + AW'(1));
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               st_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SETUP: begin
            xlast_in = COL_CALC_W'(col_x0 + COL_CALC_W'(cmd_w_ff) - COL_CALC_W'(1));
            xend_in  = (xlast_in >= COL_CALC_W'(COLUMNS)) ? COL_CALC_W'(COLUMNS - 1)
                                                         : xlast_in;
            y1raw_in = ROW_CALC_W'(row_y0 + ROW_CALC_W'(cmd_h_ff) - ROW_CALC_W'(1));
            y1c_in   = (y1raw_in >= ROW_CALC_W'(ROWS)) ? ROW_CALC_W'(ROWS - 1) : y1raw_in;
            pg_in    = row_y0[ROW_CALC_W-1:3];
            col_in   = col_x0;
            st_in    = rect_empty ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            wr_pend_in = 1'b1;
            if (col_ff == xend_ff) begin
               col_in = col_x0;
               if (pg_ff == y1c_ff[ROW_CALC_W-1:3]) begin
                  st_in = ST_DRAIN;
               end else begin
                  pg_in = PGW'(pg_ff + PGW'(1));
               end
            end else begin
               col_in = COL_CALC_W'(col_ff + COL_CALC_W'(1));
            end
         end
         ST_DRAIN: begin
            st_in = ST_DONE;
         end
         ST_RADDR: begin
            st_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_in = read_in_range ? rd_data_ff : '0;
            st_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_ff;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_x_ff      <= cmd_x_in;
      cmd_y_ff      <= cmd_y_in;
      cmd_w_ff      <= cmd_w_in;
      cmd_h_ff      <= cmd_h_in;
      cmd_ink_ff    <= cmd_ink_in;
      cmd_solid_ff  <= cmd_solid_in;
      cmd_rpage_ff  <= cmd_rpage_in;
      cmd_rcol_ff   <= cmd_rcol_in;
      xlast_ff      <= xlast_in;
      xend_ff       <= xend_in;
      y1raw_ff      <= y1raw_in;
      y1c_ff        <= y1c_in;
      pg_ff         <= pg_in;
      col_ff        <= col_in;
      wr_addr_ff    <= wr_addr_in;
      wr_mask_ff    <= wr_mask_in;
      res_ff        <= res_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   // write-back never lands on the byte being read in the same cycle
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      (wr_pend_ff && st_ff == ST_WALK) |-> (wr_addr_ff != walk_addr))
      else $error("write-back collides with walker read");

   // store is written only by the sweep or the walker
   a_we_states : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (st_ff == ST_CLEAR || st_ff == ST_WALK || st_ff == ST_DRAIN))
      else $error("store written outside sweep or walk");

   // walker stays on the display
   a_walk_bounds : assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WALK) |-> (col_ff <= xend_ff && 5'(pg_ff) < 5'(PAGES)))
      else $error("walker left the clipped rectangle");

   // a command's result reaches the response register once it is free
   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && st_ff == ST_IDLE))
      else $error("finished result not handed over");

   // no result appears from the reset sweep
   a_reset_sweep_quiet : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_valid_ff && st_ff == ST_CLEAR))
      else $error("response raised during reset sweep");

endmodule
